### hw/rtl/spmv_pkg.sv
package spmv_pkg;

  // Field widths of the stream items.
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int ROW_W = 16;
  localparam int OP_W  = 2;

  // Stream data widths, padded to whole bytes.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 80;

  // Item opcodes carried on s_tuser.
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Saturation limits of the Q31.32 sum.
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [OP_W-1:0]  kind;      // OP_LOAD, OP_NONZERO or OP_EMPTY
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             in_range;  // index lies inside the vector memory
  } item_t;

endpackage

### hw/rtl/spmv_front.sv
module spmv_front #(
  parameter int VEC_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [spmv_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  input  logic [spmv_pkg::OP_W-1:0]    s_tuser,
  output logic                         q_valid,
  output spmv_pkg::item_t              q_item,
  input  logic                         q_pop
);

  localparam int CMP_W = 17;

  spmv_pkg::item_t                 entries [spmv_pkg::QUEUE_DEPTH];
  logic [spmv_pkg::QPTR_W-1:0]     wr_ptr;
  logic [spmv_pkg::QPTR_W-1:0]     rd_ptr;
  logic [spmv_pkg::QPTR_W:0]       count;
  spmv_pkg::item_t                 item;
  logic                            keep;
  logic                            push;

  always_comb begin
    item.kind     = s_tuser;
    item.index    = s_tdata[spmv_pkg::IDX_W-1:0];
    item.value    = s_tdata[spmv_pkg::IDX_W +: spmv_pkg::VAL_W];
    item.last     = s_tlast;
    item.in_range = CMP_W'(item.index) < CMP_W'(VEC_DEPTH);
    // Loads outside the memory and the unused opcode change nothing.
    unique case (s_tuser)
      spmv_pkg::OP_LOAD:    keep = item.in_range;
      spmv_pkg::OP_NONZERO: keep = 1'b1;
      spmv_pkg::OP_EMPTY:   keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign s_tready = count != (spmv_pkg::QPTR_W+1)'(spmv_pkg::QUEUE_DEPTH);
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = count != '0;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/spmv_back.sv
module spmv_back #(
  parameter int VEC_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  spmv_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spmv_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);

  localparam int AW = $clog2(VEC_DEPTH);
  localparam int XW = (AW > spmv_pkg::IDX_W) ? AW : spmv_pkg::IDX_W;

  logic [spmv_pkg::VAL_W-1:0] mem [VEC_DEPTH];

  logic                               advance;
  logic [XW-1:0]                      idx_ext;
  logic [AW-1:0]                      addr;

  // Read stage.
  logic                               s1_valid;
  logic                               s1_empty;
  logic                               s1_last;
  logic                               s1_zero;
  logic signed [spmv_pkg::VAL_W-1:0]  s1_value;
  logic signed [spmv_pkg::VAL_W-1:0]  rd_data;
  logic signed [spmv_pkg::VAL_W-1:0]  elem;

  // Product stage.
  logic                               p_valid;
  logic                               p_empty;
  logic                               p_last;
  logic signed [spmv_pkg::SUM_W-1:0]  product;

  // Accumulator and output.
  logic [spmv_pkg::SUM_W-1:0]         acc;
  logic                               clip;
  logic [spmv_pkg::ROW_W-1:0]         row;
  logic [spmv_pkg::SUM_W-1:0]         sum_raw;
  logic                               ovf;
  logic [spmv_pkg::SUM_W-1:0]         sum;
  logic [spmv_pkg::SUM_W-1:0]         row_sum;
  logic [spmv_pkg::ROW_W-1:0]         row_number;
  logic                               saturated;

  assign advance = !(m_tvalid && !m_tready);
  assign q_pop   = q_valid && advance;
  assign idx_ext = XW'(q_item.index);
  assign addr    = idx_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == spmv_pkg::OP_LOAD) begin
      mem[addr] <= q_item.value;
    end
    if (q_pop && q_item.kind == spmv_pkg::OP_NONZERO) begin
      rd_data <= mem[addr];
    end
  end

  assign elem = s1_zero ? '0 : rd_data;

  always_comb begin
    sum_raw = acc + product;
    ovf     = (acc[spmv_pkg::SUM_W-1] == product[spmv_pkg::SUM_W-1]) &&
              (sum_raw[spmv_pkg::SUM_W-1] != acc[spmv_pkg::SUM_W-1]);
    if (ovf) begin
      sum = acc[spmv_pkg::SUM_W-1] ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
    end else begin
      sum = sum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_empty <= q_item.kind == spmv_pkg::OP_EMPTY;
      s1_last  <= q_item.last;
      s1_zero  <= !q_item.in_range;
      s1_value <= q_item.value;
      p_empty  <= s1_empty;
      p_last   <= s1_last;
      product  <= s1_value * elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      acc      <= '0;
      clip     <= 1'b0;
      row      <= '0;
    end else if (advance) begin
      s1_valid <= q_pop && q_item.kind != spmv_pkg::OP_LOAD;
      p_valid  <= s1_valid;
      m_tvalid <= 1'b0;
      if (p_valid) begin
        if (p_empty) begin
          row_sum    <= '0;
          row_number <= row;
          saturated  <= 1'b0;
          m_tvalid   <= 1'b1;
          row        <= row + 1'b1;
          acc        <= '0;
          clip       <= 1'b0;
        end else if (p_last) begin
          row_sum    <= sum;
          row_number <= row;
          saturated  <= clip || ovf;
          m_tvalid   <= 1'b1;
          row        <= row + 1'b1;
          acc        <= '0;
          clip       <= 1'b0;
        end else begin
          acc  <= sum;
          clip <= clip || ovf;
        end
      end
    end
  end

  assign m_tdata = {row_number, row_sum};
  assign m_tuser = saturated;

endmodule

### hw/rtl/csr_sparse_matrix_vector_multiply.sv
// Sparse matrix times dense vector in CSR order. Each input transaction is
// one item: a load (s_tuser = 0) writes a Q16.16 element into the vector
// memory, a nonzero (s_tuser = 1) multiplies its Q16.16 value by the stored
// element at its column and adds the exact product to a saturating Q31.32
// row sum, and an empty row (s_tuser = 2) emits a zero sum. The nonzero that
// carries s_tlast closes its row and emits the sum, the wrapping row number
// and a flag that tells whether the sum clipped anywhere in the row. A vector
// element must be loaded before any nonzero reads it. The block takes one
// transaction per clock unless m_tready stalls the output; the closing
// transaction passes the queue, read stage, product stage and output register.
// The rate is set by the single multiply-accumulate path, which handles one
// nonzero per cycle unless stalled. A four-entry queue separates input
// decoding from the memory read, multiply and accumulate stages, so the input
// keeps flowing for up to four queued items while a finished result waits on m_tready.
module csr_sparse_matrix_vector_multiply #(
  parameter int VEC_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // index [9:0], value [41:10], zero padding [47:42]
  input  logic [spmv_pkg::S_TDATA_W-1:0] s_tdata,
  // row_end
  input  logic                           s_tlast,
  // opcode [1:0]
  input  logic [spmv_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // row_sum [63:0], row_number [79:64]
  output logic [spmv_pkg::M_TDATA_W-1:0] m_tdata,
  // saturated
  output logic                           m_tuser
);

  // Queue handshake between the decoding front and the arithmetic back.
  logic            q_valid;
  logic            q_pop;
  spmv_pkg::item_t q_item;

  // The front decodes each transaction, drops loads beyond the memory and
  // unused opcodes, and buffers the rest in order.
  spmv_front #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back owns the vector memory, the multiplier and the row accumulator.
  // Loads and reads happen in queue order, so a load is always visible to
  // the nonzeros that follow it.
  spmv_back #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
